### src/esss_pkg.sv
package esss_pkg;

  // number of spectrum slots on a link
  localparam int SLOT_COUNT = 64;

  // field widths
  localparam int MASK_W = 64;
  localparam int NEED_W = 7;
  localparam int SLOT_W = 6;

  // lowest-slot search tree: groups of eight cells
  localparam int GROUP_W = 8;
  localparam int GIDX_W  = 3;
  localparam int GROUP_N = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
  localparam int PAD_W   = GROUP_N * GROUP_W;

  typedef logic [NEED_W-1:0] need_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [GIDX_W-1:0] gidx_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic accum;  // and this link into the common mask
    logic load;   // last link: freeze the mask, start a window scan
    logic step;   // one window step, shift data one cell down
  } cell_ctrl_t;

  // lowest hits found by the search tree
  typedef struct packed {
    logic  exact_any;
    slot_t exact_start;
    logic  fit_any;
    slot_t fit_start;
  } hit_t;

endpackage

### src/esss_cell.sv
module esss_cell (
  input  logic                clk,
  input  logic                rst,
  input  esss_pkg::cell_ctrl_t ctrl,
  input  logic                link_bit,
  input  logic                left_bit,
  input  logic                shift_in,
  output logic                mask_bit,
  output logic                shift_bit,
  output logic                fit_bit,
  output logic                exact_bit
);

  logic free;   // running and of the link masks
  logic mbit;   // frozen common mask bit for the current search
  logic s;      // mask bit of the slot "steps" cells above
  logic acc;    // every slot of the window so far is free

  logic free_and;

  assign free_and = free & link_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= 1'b1;
    end else if (ctrl.load) begin
      free <= 1'b1;
    end else if (ctrl.accum) begin
      free <= free_and;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mbit <= free_and;
      s    <= free_and;
      acc  <= 1'b1;
    end else if (ctrl.step) begin
      acc  <= acc & s;
      s    <= shift_in;
    end
  end

  assign mask_bit  = mbit;
  assign shift_bit = s;
  assign fit_bit   = acc;
  // run starts here, the slot below is taken and the slot just past it too
  assign exact_bit = acc & ~s & ~left_bit;

endmodule

### src/esss_find.sv
module esss_find (
  input  logic                        clk,
  input  logic [esss_pkg::PAD_W-1:0]  exact_vec,
  input  logic [esss_pkg::PAD_W-1:0]  fit_vec,
  output esss_pkg::hit_t              hit
);

  logic [esss_pkg::GROUP_N-1:0] e_any;
  logic [esss_pkg::GROUP_N-1:0] f_any;
  logic [esss_pkg::GROUP_N-1:0] e_any_next;
  logic [esss_pkg::GROUP_N-1:0] f_any_next;
  esss_pkg::gidx_t e_idx      [esss_pkg::GROUP_N];
  esss_pkg::gidx_t f_idx      [esss_pkg::GROUP_N];
  esss_pkg::gidx_t e_idx_next [esss_pkg::GROUP_N];
  esss_pkg::gidx_t f_idx_next [esss_pkg::GROUP_N];

  // first level: lowest set bit inside each group of eight
  always_comb begin
    for (int g = 0; g < esss_pkg::GROUP_N; g++) begin
      e_any_next[g] = 1'b0;
      f_any_next[g] = 1'b0;
      e_idx_next[g] = '0;
      f_idx_next[g] = '0;
      for (int j = esss_pkg::GROUP_W - 1; j >= 0; j--) begin
        if (exact_vec[g*esss_pkg::GROUP_W + j]) begin
          e_any_next[g] = 1'b1;
          e_idx_next[g] = esss_pkg::gidx_t'(j);
        end
        if (fit_vec[g*esss_pkg::GROUP_W + j]) begin
          f_any_next[g] = 1'b1;
          f_idx_next[g] = esss_pkg::gidx_t'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    e_any <= e_any_next;
    f_any <= f_any_next;
    e_idx <= e_idx_next;
    f_idx <= f_idx_next;
  end

  // second level: lowest group with a hit
  always_comb begin
    hit = '0;
    for (int g = esss_pkg::GROUP_N - 1; g >= 0; g--) begin
      if (e_any[g]) begin
        hit.exact_any   = 1'b1;
        hit.exact_start = esss_pkg::slot_t'(g * esss_pkg::GROUP_W)
                          | esss_pkg::slot_t'(e_idx[g]);
      end
      if (f_any[g]) begin
        hit.fit_any   = 1'b1;
        hit.fit_start = esss_pkg::slot_t'(g * esss_pkg::GROUP_W)
                        | esss_pkg::slot_t'(f_idx[g]);
      end
    end
  end

endmodule

### src/exact_fit_spectrum_slot_search.sv
// channel | signals                                      | direction
// --------+----------------------------------------------+----------
// in      | in_valid, in_stall,                          | item in
//         | link_free_mask, required_slots, last_link    |
// out     | out_valid, out_stall,                        | item out
//         | found, exact_hole, start_slot                |
//
// an item that is not last only has its mask anded into the cells
// a last item is also anded in, then the cell row grows the window one slot
// per step, then the two tree levels register and pick the lowest hit
// (no scan when required_slots is zero or above the slot count)
// reset (rst, synchronous) marks every slot free and empties the output
// in_stall is high from a last item until its result item has been taken

module exact_fit_spectrum_slot_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [esss_pkg::MASK_W-1:0]  link_free_mask,
  input  logic [esss_pkg::NEED_W-1:0]  required_slots,
  input  logic                         last_link,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic                         exact_hole,
  output logic [esss_pkg::SLOT_W-1:0]  start_slot
);

  typedef enum logic [2:0] {
    S_IDLE,   // taking link items
    S_SCAN,   // cell row grows the window one slot per cycle
    S_TREE,   // first tree level registers group hits
    S_PICK,   // second tree level picks the lowest group
    S_OUT     // result item waits to be taken
  } state_t;

  state_t              state;
  esss_pkg::need_t     cnt;      // window steps still to go
  logic                need_ok;  // required count is in range
  logic                accept;
  esss_pkg::cell_ctrl_t ctrl;
  esss_pkg::hit_t      hit;

  // cell row wiring, padded with zeros up to the tree width
  logic [esss_pkg::PAD_W-1:0]      exact_vec;
  logic [esss_pkg::PAD_W-1:0]      fit_vec;
  logic [esss_pkg::SLOT_COUNT-1:0] mask_row;
  logic [esss_pkg::SLOT_COUNT-1:0] shift_row;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign ctrl.accum = accept;
  assign ctrl.load  = accept && last_link;
  assign ctrl.step  = (state == S_SCAN);

  // one cell per slot; the window data walks down toward slot 0
  for (genvar i = 0; i < esss_pkg::SLOT_COUNT; i++) begin : g_cell
    logic left_bit;
    logic shift_in;

    if (i == 0) begin : g_low
      assign left_bit = 1'b0;
    end else begin : g_mid
      assign left_bit = mask_row[i-1];
    end

    // no slot above the top one: reads as taken
    if (i == esss_pkg::SLOT_COUNT - 1) begin : g_top
      assign shift_in = 1'b0;
    end else begin : g_inner
      assign shift_in = shift_row[i+1];
    end

    esss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .link_bit  (link_free_mask[i]),
      .left_bit  (left_bit),
      .shift_in  (shift_in),
      .mask_bit  (mask_row[i]),
      .shift_bit (shift_row[i]),
      .fit_bit   (fit_vec[i]),
      .exact_bit (exact_vec[i])
    );
  end

  if (esss_pkg::PAD_W > esss_pkg::SLOT_COUNT) begin : g_pad
    assign fit_vec[esss_pkg::PAD_W-1:esss_pkg::SLOT_COUNT]   = '0;
    assign exact_vec[esss_pkg::PAD_W-1:esss_pkg::SLOT_COUNT] = '0;
  end

  esss_find u_find (
    .clk       (clk),
    .exact_vec (exact_vec),
    .fit_vec   (fit_vec),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.load) begin
            cnt     <= required_slots;
            need_ok <= (required_slots != '0) &&
                       (required_slots <= esss_pkg::need_t'(esss_pkg::SLOT_COUNT));
            // an out of range count finds nothing, skip the scan
            if ((required_slots != '0) &&
                (required_slots <= esss_pkg::need_t'(esss_pkg::SLOT_COUNT))) begin
              state <= S_SCAN;
            end else begin
              state <= S_TREE;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt - esss_pkg::need_t'(1);
          if (cnt == esss_pkg::need_t'(1)) begin
            state <= S_TREE;
          end
        end
        S_TREE: begin
          state <= S_PICK;
        end
        S_PICK: begin
          // an exact hole wins over the first fit block
          found      <= need_ok && (hit.exact_any || hit.fit_any);
          exact_hole <= need_ok && hit.exact_any;
          if (!need_ok) begin
            start_slot <= '0;
          end else if (hit.exact_any) begin
            start_slot <= hit.exact_start;
          end else if (hit.fit_any) begin
            start_slot <= hit.fit_start;
          end else begin
            start_slot <= '0;
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no new item is taken while a result waits
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  // one result per last item: it leaves after being taken
  a_single_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result shown twice");

  // a miss reports slot zero and no exact hole
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (start_slot == '0) && !exact_hole)
    else $error("miss with nonzero fields");

  // a last item always starts a search: the scan, or the tree if the scan is skipped
  a_load_to_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && last_link) |=> (state == S_SCAN || state == S_TREE))
    else $error("last item did not start a search");

endmodule
